// File: rtl/scmd_pkg.sv
`timescale 1ns / 1ps
package scmd_pkg;

	localparam int SW = 24;
	localparam int RING_DEPTH = 2048;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int SINE_N = 1024;
	localparam int SINE_AW = $clog2(SINE_N);
	localparam logic [18:0] DELAY_MAX = 19'((RING_DEPTH - 1) * 256);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// register indexes on the config port
	localparam logic [2:0] REG_PHASE_STEP = 3'd0;
	localparam logic [2:0] REG_BASE_DELAY = 3'd1;
	localparam logic [2:0] REG_DEPTH      = 3'd2;
	localparam logic [2:0] REG_OFFSET     = 3'd3;
	localparam logic [2:0] REG_DRY_GAIN   = 3'd4;
	localparam logic [2:0] REG_WET_GAIN   = 3'd5;
	localparam logic [2:0] REG_STEREO     = 3'd6;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_SIN,
		STEP_DLY,
		STEP_RD,
		STEP_LERP,
		STEP_WET,
		STEP_MIXW,
		STEP_SAT
	} step_t;

	typedef struct packed {
		step_t              step;
		logic               ch;
		logic               capture;
		logic               adv;
		logic               clr;
		logic [RING_AW-1:0] clr_addr;
		logic               load_out;
	} cmd_t;

	typedef struct packed {
		logic stereo;
	} status_t;

	typedef logic signed [15:0] sine_rom_t [SINE_N];

	// quarter-wave taylor series, q1.15 result
	function automatic logic signed [15:0] sine_q15(input logic [31:0] u);
		logic [63:0] t;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [15:0] r;
		logic [1:0] quad;
		quad = u[31:30];
		t = {34'd0, u[29:0]};
		if (quad[0])
			t = 64'h4000_0000 - t;
		a = (t * HALF_PI_Q30) >> 30;
		a2 = (a * a) >> 30;
		term = a;
		sum = $signed(a);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = 0;
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32767)
			sum = 64'sd32767;
		r = sum[15:0];
		return quad[1] ? -r : r;
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		for (int k = 0; k < SINE_N; k++)
			rom[k] = sine_q15({k[SINE_AW-1:0], {(32 - SINE_AW){1'b0}}});
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// File: rtl/scmd_ring.sv
`timescale 1ns / 1ps
module scmd_ring (
	input  logic                          clk,
	input  logic                          we,
	input  logic [scmd_pkg::RING_AW-1:0]  waddr,
	input  logic signed [scmd_pkg::SW-1:0] wdata,
	input  logic [scmd_pkg::RING_AW-1:0]  raddr_a,
	input  logic [scmd_pkg::RING_AW-1:0]  raddr_b,
	output logic signed [scmd_pkg::SW-1:0] rdata_a,
	output logic signed [scmd_pkg::SW-1:0] rdata_b
);
	import scmd_pkg::*;

	logic signed [SW-1:0] mem [RING_DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: rtl/scmd_ctrl.sv
`timescale 1ns / 1ps
module scmd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  scmd_pkg::status_t status,
	output scmd_pkg::cmd_t    cmd
);
	import scmd_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SIN, S_DLY, S_RD, S_LERP, S_WET, S_MIXW, S_SAT, S_FIN
	} state_t;

	state_t             state_q;
	logic               ch_q;
	logic [RING_AW-1:0] clr_q;
	logic               load;
	logic               last_ch;

	assign in_ready = (state_q == S_IDLE);
	assign load     = (state_q == S_FIN) && (!out_valid || out_ready);
	assign last_ch  = ch_q || !status.stereo;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.step     = STEP_NONE;
		cmd.ch       = ch_q;
		cmd.clr_addr = clr_q;
		cmd.load_out = load;
		cmd.capture  = in_valid && in_ready;
		case (state_q)
			S_CLEAR: cmd.clr  = 1'b1;
			S_SIN:   cmd.step = STEP_SIN;
			S_DLY:   cmd.step = STEP_DLY;
			S_RD:    cmd.step = STEP_RD;
			S_LERP:  cmd.step = STEP_LERP;
			S_WET:   cmd.step = STEP_WET;
			S_MIXW:  cmd.step = STEP_MIXW;
			S_SAT: begin
				cmd.step = STEP_SAT;
				cmd.adv  = last_ch;
			end
			default: cmd.step = STEP_NONE;
		endcase
	end

	// sequencer and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ch_q      <= 1'b0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= 1'b0;
						state_q <= S_SIN;
					end
				end
				S_SIN:  state_q <= S_DLY;
				S_DLY:  state_q <= S_RD;
				S_RD:   state_q <= S_LERP;
				S_LERP: state_q <= S_WET;
				S_WET:  state_q <= S_MIXW;
				S_MIXW: state_q <= S_SAT;
				S_SAT: begin
					if (last_ch) begin
						state_q <= S_FIN;
					end else begin
						ch_q    <= 1'b1;
						state_q <= S_SIN;
					end
				end
				S_FIN: begin
					if (load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SIN && !ch_q))
		else $error("accepted beat did not start left channel");
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside finish");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before taken");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !cmd.capture)
		else $error("beat accepted during ring clear");

endmodule

// File: rtl/scmd_datapath.sv
`timescale 1ns / 1ps
module scmd_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scmd_pkg::cmd_t                 cmd,
	output scmd_pkg::status_t              status,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic signed [scmd_pkg::SW-1:0] sample_left,
	input  logic signed [scmd_pkg::SW-1:0] sample_right,
	output logic signed [scmd_pkg::SW-1:0] out_left,
	output logic signed [scmd_pkg::SW-1:0] out_right
);
	import scmd_pkg::*;

	localparam logic signed [SW-1:0] SAT_HI = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {1'b1, {(SW - 1){1'b0}}};

	// config registers
	logic [31:0] step_q;
	logic [18:0] base_q;
	logic [18:0] depth_q;
	logic [30:0] offset_q;
	logic [15:0] dry_q;
	logic [15:0] wet_g_q;
	logic        stereo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			base_q   <= '0;
			depth_q  <= '0;
			offset_q <= '0;
			dry_q    <= 16'd16384;
			wet_g_q  <= 16'd16384;
			stereo_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_STEP: step_q   <= cfg_data;
				REG_BASE_DELAY: base_q   <= cfg_data[18:0];
				REG_DEPTH:      depth_q  <= cfg_data[18:0];
				REG_OFFSET:     offset_q <= cfg_data[30:0];
				REG_DRY_GAIN:   dry_q    <= cfg_data[15:0];
				REG_WET_GAIN:   wet_g_q  <= cfg_data[15:0];
				REG_STEREO:     stereo_q <= cfg_data[0];
				default:        stereo_q <= stereo_q;
			endcase
		end
	end

	assign status.stereo = stereo_q;

	// lfo phase and write pointer
	logic [31:0]        phase_q;
	logic [RING_AW-1:0] wp_q;
	logic [31:0]        ch_phase;

	assign ch_phase = cmd.ch ? (phase_q + {1'b0, offset_q}) : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wp_q    <= '0;
		end else begin
			if (cmd.step == STEP_SIN && !cmd.ch)
				phase_q <= phase_q + step_q;
			if (cmd.adv)
				wp_q <= wp_q + 1'b1;
		end
	end

	// captured input pair
	logic signed [SW-1:0] xl_q;
	logic signed [SW-1:0] xr_q;
	logic signed [SW-1:0] x_ch;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			xl_q <= sample_left;
			xr_q <= sample_right;
		end
	end

	assign x_ch = cmd.ch ? xr_q : xl_q;

	// rings
	logic [RING_AW-1:0]   waddr;
	logic signed [SW-1:0] wdata;
	logic                 we_l;
	logic                 we_r;
	logic [RING_AW-1:0]   ia;
	logic [RING_AW-1:0]   ib;
	logic signed [SW-1:0] la;
	logic signed [SW-1:0] lb;
	logic signed [SW-1:0] ra;
	logic signed [SW-1:0] rb;
	logic [18:0]          d_q;

	assign waddr = cmd.clr ? cmd.clr_addr : wp_q;
	assign wdata = cmd.clr ? '0 : x_ch;
	assign we_l  = cmd.clr || (cmd.step == STEP_SIN && !cmd.ch);
	assign we_r  = cmd.clr || (cmd.step == STEP_SIN && cmd.ch);
	assign ia    = wp_q - d_q[18:8];
	assign ib    = ia - 1'b1;

	scmd_ring u_left_ring (
		.clk     (clk),
		.we      (we_l),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (ia),
		.raddr_b (ib),
		.rdata_a (la),
		.rdata_b (lb)
	);

	scmd_ring u_right_ring (
		.clk     (clk),
		.we      (we_r),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (ia),
		.raddr_b (ib),
		.rdata_a (ra),
		.rdata_b (rb)
	);

	// sine lookup and delay
	logic signed [15:0] sine_s1;
	logic signed [35:0] mod_prod;
	logic signed [21:0] d_sum;

	assign mod_prod = $signed({17'd0, depth_q}) * 36'(sine_s1);
	assign d_sum    = $signed({3'd0, base_q}) + 22'(mod_prod >>> 15);

	// interpolation and mix
	logic signed [SW-1:0] a_ch;
	logic signed [SW-1:0] b_ch;
	logic signed [SW:0]   diff;
	logic signed [SW+9:0] lerp_s3;
	logic signed [SW:0]   wet_s4;
	logic signed [SW+17:0] dry_s4;
	logic signed [SW+17:0] wmix_s5;
	logic signed [SW+18:0] acc;
	logic signed [SW+4:0]  acc_sh;
	logic signed [SW-1:0]  sat;
	logic signed [SW-1:0]  res_l_q;
	logic signed [SW-1:0]  res_r_q;

	assign a_ch = cmd.ch ? ra : la;
	assign b_ch = cmd.ch ? rb : lb;
	assign diff = (SW + 1)'(b_ch) - (SW + 1)'(a_ch);
	assign acc  = (SW + 19)'(dry_s4) + (SW + 19)'(wmix_s5) + (SW + 19)'(8192);
	assign acc_sh = (SW + 5)'(acc >>> 14);

	always_comb begin
		if (acc_sh > (SW + 5)'(SAT_HI))
			sat = SAT_HI;
		else if (acc_sh < (SW + 5)'(SAT_LO))
			sat = SAT_LO;
		else
			sat = acc_sh[SW-1:0];
	end

	// step registers
	always_ff @(posedge clk) begin
		case (cmd.step)
			STEP_SIN: sine_s1 <= SINE_ROM[ch_phase[31 -: SINE_AW]];
			STEP_DLY: begin
				if (d_sum < 0)
					d_q <= '0;
				else if (d_sum > $signed({3'd0, DELAY_MAX}))
					d_q <= DELAY_MAX;
				else
					d_q <= d_sum[18:0];
			end
			STEP_LERP: lerp_s3 <= (SW + 10)'(diff) * $signed({{(SW + 1){1'b0}}, d_q[7:0]});
			STEP_WET: begin
				wet_s4 <= (SW + 1)'(a_ch) + (SW + 1)'(lerp_s3 >>> 8);
				dry_s4 <= (SW + 18)'(x_ch) * $signed({{(SW + 1){1'b0}}, dry_q});
			end
			STEP_MIXW: wmix_s5 <= (SW + 18)'(wet_s4) * $signed({{SW{1'b0}}, 1'b0, wet_g_q});
			STEP_SAT: begin
				if (cmd.ch)
					res_r_q <= sat;
				else
					res_l_q <= sat;
			end
			default: d_q <= d_q;
		endcase
		if (cmd.capture)
			res_r_q <= '0;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_left  <= res_l_q;
			out_right <= res_r_q;
		end
	end

endmodule

// File: rtl/stereo_chorus_modulated_delay_unit.sv
`timescale 1ns / 1ps
// Stereo chorus: each input beat is one stereo sample pair and gives one output beat. The
// block runs one pair at a time through a shared sequencer of seven steps per channel (sine
// lookup and ring write, delay compute, dual-port ring read, interpolation multiply, wet
// sum with dry multiply, wet multiply, round and saturate); the next pair is accepted
// while the result waits in the output register. After reset the two 2048-entry delay
// rings are cleared to zero, one entry a cycle, and no input beat is accepted until the
// clear is done; config writes are taken at any time but should only be made while idle.
module stereo_chorus_modulated_delay_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [scmd_pkg::SW-1:0] sample_left,
	input  logic signed [scmd_pkg::SW-1:0] sample_right,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [scmd_pkg::SW-1:0] out_left,
	output logic signed [scmd_pkg::SW-1:0] out_right
);
	import scmd_pkg::*;

	cmd_t    cmd;
	status_t status;

	scmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	scmd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.out_left     (out_left),
		.out_right    (out_right)
	);

endmodule

// File: dv/stereo_chorus_modulated_delay_unit_tb.sv
`timescale 1ns / 1ps
module stereo_chorus_modulated_delay_unit_tb;
	import scmd_pkg::*;

	localparam int LIMIT = 3000000;
	localparam int SETTLE = 40;

	typedef logic signed [SW-1:0] smp_t;
	typedef struct packed {
		smp_t l;
		smp_t r;
	} pair_t;

	// directed rows: a known expectation is typed in where has_exp is set
	typedef struct packed {
		smp_t l;
		smp_t r;
		logic has_exp;
		smp_t el;
		smp_t er;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	smp_t sample_left = '0;
	smp_t sample_right = '0;
	logic out_valid;
	logic out_ready = 0;
	smp_t out_left;
	smp_t out_right;

	stereo_chorus_modulated_delay_unit dut (.*);

	always #5 clk = ~clk;

	// chorus predictor state
	logic signed [15:0] sine_lut [SINE_N];
	smp_t ring_l [RING_DEPTH];
	smp_t ring_r [RING_DEPTH];
	logic [RING_AW-1:0] wr_ptr;
	logic [31:0] phase_acc;
	logic [31:0] c_step;
	logic [18:0] c_base, c_depth;
	logic [30:0] c_offset;
	logic [15:0] c_dry, c_wet;
	logic c_stereo;

	pair_t mix_q[$];
	int fails = 0;
	int send_idle = 0, recv_stall = 0;
	int hold_off = 0;
	longint cycles = 0;

	// quarter-wave series, independent of the package function
	function automatic logic signed [15:0] sine_entry(input logic [31:0] u);
		longint unsigned t, a, a2, term;
		longint s;
		t = u & 32'h3FFF_FFFF;
		if (u[30])
			t = 64'h4000_0000 - t;
		a = (t * 64'd1686629713) >> 30;
		a2 = (a * a) >> 30;
		term = a;
		s = a;
		for (int n = 1; n <= 6; n++) begin
			term = ((term * a2) >> 30) / ((2 * n) * (2 * n + 1));
			s = (n % 2) ? s - longint'(term) : s + longint'(term);
		end
		if (s < 0)
			s = 0;
		s = (s + 16384) >>> 15;
		if (s > 32767)
			s = 32767;
		return u[31] ? -16'(s) : 16'(s);
	endfunction

	// floor shift for signed values
	function automatic longint floor_shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic smp_t chorus_channel(input bit right, input smp_t x, input logic [31:0] ph);
		longint d, di, fr, a, b, wet, acc;
		logic [RING_AW-1:0] ia, ib;
		d = longint'(c_base) + floor_shr(longint'(c_depth) * sine_lut[ph[31:22]], 15);
		if (d < 0)
			d = 0;
		if (d > (RING_DEPTH - 1) * 256)
			d = (RING_DEPTH - 1) * 256;
		di = d >> 8;
		fr = d & 255;
		ia = RING_AW'(wr_ptr - di);
		ib = RING_AW'(wr_ptr - di - 1);
		if (right) begin
			ring_r[wr_ptr] = x;
			a = ring_r[ia];
			b = ring_r[ib];
		end else begin
			ring_l[wr_ptr] = x;
			a = ring_l[ia];
			b = ring_l[ib];
		end
		wet = a + floor_shr((b - a) * fr, 8);
		acc = floor_shr(longint'(x) * c_dry + wet * c_wet + 8192, 14);
		if (acc > 8388607)
			acc = 8388607;
		if (acc < -8388608)
			acc = -8388608;
		return smp_t'(acc);
	endfunction

	function automatic pair_t chorus_predict(input pair_t s);
		pair_t o;
		logic [31:0] lp, rp;
		lp = phase_acc;
		phase_acc = phase_acc + c_step;
		rp = phase_acc + {1'b0, c_offset};
		o.l = chorus_channel(0, s.l, lp);
		o.r = c_stereo ? chorus_channel(1, s.r, rp) : '0;
		wr_ptr = wr_ptr + 1'b1;
		return o;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_PHASE_STEP: c_step = val;
			REG_BASE_DELAY: c_base = val[18:0];
			REG_DEPTH:      c_depth = val[18:0];
			REG_OFFSET:     c_offset = val[30:0];
			REG_DRY_GAIN:   c_dry = val[15:0];
			REG_WET_GAIN:   c_wet = val[15:0];
			REG_STEREO:     c_stereo = val[0];
			default: ;
		endcase
	endtask

	// send one beat, push the prediction (or the typed expectation) on accept
	task automatic send_pair(input pair_t s, input bit has_exp, input pair_t e);
		pair_t p;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		sample_left <= s.l;
		sample_right <= s.r;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		p = chorus_predict(s);
		if (has_exp && p != e) begin
			$error("directed row predicted %0d/%0d, typed %0d/%0d", p.l, p.r, e.l, e.r);
			fails++;
		end
		mix_q.push_back(has_exp ? e : p);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (mix_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic smp_t rnd_smp();
		case ($urandom_range(5))
			0: return smp_t'(24'h7FFFFF);
			1: return smp_t'(24'h800000);
			default: return smp_t'($urandom);
		endcase
	endfunction

	// receiver with random stalls and a long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// check each result beat
	always @(posedge clk) begin
		pair_t e;
		if (arst_n && out_valid && out_ready) begin
			if (mix_q.size() == 0) begin
				$error("unexpected result beat %0d/%0d", out_left, out_right);
				fails++;
			end else begin
				e = mix_q.pop_front();
				if (out_left !== e.l) begin
					$error("out_left expected %0d actual %0d", e.l, out_left);
					fails++;
				end
				if (out_right !== e.r) begin
					$error("out_right expected %0d actual %0d", e.r, out_right);
					fails++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("stereo_chorus_modulated_delay_unit test failed");
			$finish;
		end
	end

	row_t dir_rows[] = '{
		'{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
		'{24'sh7FFFFF, 24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh800000},
		'{24'sh800000, 24'sh7FFFFF, 1'b1, 24'sh800000, 24'sh7FFFFF},
		'{24'sd1, -24'sd1, 1'b1, 24'sd2, -24'sd2},
		'{24'sd1000, -24'sd1000, 1'b0, 24'sd0, 24'sd0},
		'{24'sh555555, 24'shAAAAAA, 1'b0, 24'sd0, 24'sd0}
	};

	// typed expectations only hold at reset settings
	task automatic run_rows(input bit use_exp);
		pair_t s, e;
		foreach (dir_rows[i]) begin
			s = '{dir_rows[i].l, dir_rows[i].r};
			e = '{dir_rows[i].el, dir_rows[i].er};
			send_pair(s, use_exp && dir_rows[i].has_exp, e);
		end
	endtask

	task automatic run_random(input int n);
		pair_t s, z;
		z = '0;
		repeat (n) begin
			s = '{rnd_smp(), rnd_smp()};
			send_pair(s, 0, z);
		end
	endtask

	initial begin
		for (int k = 0; k < SINE_N; k++)
			sine_lut[k] = sine_entry(32'(k) << 22);
		foreach (ring_l[i]) begin
			ring_l[i] = '0;
			ring_r[i] = '0;
		end
		wr_ptr = '0;
		phase_acc = '0;
		c_step = 0; c_base = 0; c_depth = 0; c_offset = 0;
		c_dry = 16384; c_wet = 16384; c_stereo = 1;
		repeat (4) @(negedge clk);
		arst_n <= 1;

		// reset settings: zero delay doubles the input, saturating at the extremes
		run_rows(1);
		drain();

		// directed: mono, deepest delays, max gains
		write_reg(REG_STEREO, 0);
		write_reg(REG_DRY_GAIN, 32768);
		write_reg(REG_WET_GAIN, 0);
		run_rows(0);
		drain();
		write_reg(REG_STEREO, 1);
		write_reg(REG_BASE_DELAY, 523775);
		write_reg(REG_DEPTH, 523775);
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_OFFSET, 32'h4000_0000);
		write_reg(REG_WET_GAIN, 32768);
		run_random(12);
		drain();

		// random phases with varied settings and idling
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 65; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 65; end
				default: begin send_idle = 21; recv_stall = 21; end
			endcase
			write_reg(REG_PHASE_STEP, (ph == 4) ? 32'hFFFF_FFFF : $urandom);
			write_reg(REG_BASE_DELAY, (ph == 5) ? 523775 : $urandom_range(600 * 256));
			write_reg(REG_DEPTH, (ph == 6) ? 523775 : $urandom_range(400 * 256));
			write_reg(REG_OFFSET, $urandom_range(32'h4000_0000));
			write_reg(REG_DRY_GAIN, (ph == 2) ? 0 : $urandom_range(32768));
			write_reg(REG_WET_GAIN, (ph == 3) ? 32768 : $urandom_range(32768));
			write_reg(REG_STEREO, (ph % 3) != 1);
			if (ph == 1)
				hold_off <= 400;
			run_random(195);
			drain();
		end

		if (fails == 0 && mix_q.size() == 0)
			$display("stereo_chorus_modulated_delay_unit test passed");
		else
			$display("stereo_chorus_modulated_delay_unit test failed");
		$finish;
	end

endmodule
